@@ sv/wlpl_pkg.sv @@
// Shared constants, word types and cell control struct for the wavio length unit.
// No dependencies; every other file in this folder imports this package.
package wlpl_pkg;

    localparam int MAX_LEN     = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(MAX_LEN);
    localparam int CNT_W       = $clog2(MAX_LEN + 1);
    localparam int LEN_W       = 11;

    typedef logic [VALUE_WIDTH-1:0] key_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } item_word_t;

    typedef struct packed {
        logic [LEN_W-1:0] wavio_length;
        logic             overflow;
    } result_word_t;

    // Control that the sequencer broadcasts to every cell of the tails row.
    typedef struct packed {
        logic en;
        logic clr;
    } cell_ctl_t;

    // Flipping the sign bit makes unsigned order match signed order.
    function automatic key_t to_key(input logic [31:0] raw);
        key_t k;
        k = key_t'(raw);
        k[VALUE_WIDTH-1] = ~k[VALUE_WIDTH-1];
        return k;
    endfunction

endpackage

@@ sv/wavio_longest_peak_length_unit.sv @@
// Wavio length unit: the forward pass takes one word per cycle. After the last word the
// backward pass replays the N stored words at one per cycle; the input stalls from the
// last word until the result word is loaded, and then the next sequence can start. An
// earlier result that is still stalled delays both. The tails row settles one insert
// per cycle.
// Reset clears all control state and the cell valid bits at once; no clearing pass.
module wavio_longest_peak_length_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  wlpl_pkg::item_word_t  item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output wlpl_pkg::result_word_t result
);
    import wlpl_pkg::*;

    localparam logic [2:0] S_FWD   = 3'd0;
    localparam logic [2:0] S_CLR   = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [LEN_W-1:0] best_reg, best_next;
    logic             fl_wr_reg;
    logic [IDX_W-1:0] fl_addr_reg;
    logic             p1_valid_reg, p2_valid_reg;
    logic [LEN_W-1:0] fl_p2_reg;
    key_t             seq_rd_reg;
    logic [LEN_W-1:0] fl_rd_reg;
    logic             result_valid_reg, result_valid_next;
    result_word_t     result_reg;

    key_t             seq_mem [MAX_LEN];
    logic [LEN_W-1:0] fl_mem  [MAX_LEN];

    logic             accept;
    logic             store;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             load_result;
    cell_ctl_t        ctl;
    key_t             cell_key;
    logic [IDX_W-1:0] pos;
    logic [MAX_LEN-1:0] hits;
    logic [LEN_W-1:0] ins_len;
    logic [LEN_W-1:0] min_len;
    logic [LEN_W-1:0] wav_len;

    assign item_stall   = (state_reg != S_FWD);
    assign accept       = item_valid && !item_stall;
    assign store        = accept && (count_reg != CNT_W'(MAX_LEN));
    assign rd_en        = (state_reg == S_RUN) && (rd_idx_reg != '0);
    assign rd_addr      = IDX_W'(rd_idx_reg - CNT_W'(1));
    assign load_result  = (state_reg == S_DONE) && (!result_valid_reg || !result_stall);

    assign ctl.en   = store || p1_valid_reg;
    assign ctl.clr  = (state_reg == S_CLR) || (state_reg == S_DONE);
    assign cell_key = (state_reg == S_FWD) ? to_key(item.value) : seq_rd_reg;

    wlpl_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .key   (cell_key),
        .pos   (pos),
        .hits  (hits)
    );

    // Length of the increasing run that ends at the element just inserted.
    assign ins_len = LEN_W'(pos) + LEN_W'(1);
    assign min_len = (fl_p2_reg < ins_len) ? fl_p2_reg : ins_len;
    assign wav_len = LEN_W'({min_len, 1'b0} - (LEN_W + 1)'(1));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        rd_idx_next = rd_idx_reg;
        best_next   = best_reg;
        if (p2_valid_reg && (wav_len > best_reg))
        begin
            best_next = wav_len;
        end
        unique case (state_reg)
            S_FWD:
            begin
                if (store)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else if (accept)
                begin
                    ovf_next = 1'b1;
                end
                if (accept && item.last)
                begin
                    state_next = S_CLR;
                end
            end
            S_CLR:
            begin
                rd_idx_next = count_reg;
                state_next  = S_RUN;
            end
            S_RUN:
            begin
                if (rd_en)
                begin
                    rd_idx_next = rd_idx_reg - CNT_W'(1);
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!p1_valid_reg && !p2_valid_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_result)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    best_next  = LEN_W'(1);
                    state_next = S_FWD;
                end
            end
            default:
            begin
                state_next = S_FWD;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load_result)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_FWD;
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            rd_idx_reg       <= '0;
            best_reg         <= LEN_W'(1);
            fl_wr_reg        <= 1'b0;
            p1_valid_reg     <= 1'b0;
            p2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            ovf_reg          <= ovf_next;
            rd_idx_reg       <= rd_idx_next;
            best_reg         <= best_next;
            fl_wr_reg        <= store;
            p1_valid_reg     <= rd_en;
            p2_valid_reg     <= p1_valid_reg;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            fl_addr_reg <= IDX_W'(count_reg);
        end
        if (p1_valid_reg)
        begin
            fl_p2_reg <= fl_rd_reg;
        end
        if (load_result)
        begin
            result_reg.wavio_length <= best_reg;
            result_reg.overflow     <= ovf_reg;
        end
    end

    // The forward length is written in the cycle after the key, once the row has settled.
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            seq_mem[IDX_W'(count_reg)] <= cell_key;
        end
        if (fl_wr_reg)
        begin
            fl_mem[fl_addr_reg] <= ins_len;
        end
        if (rd_en)
        begin
            seq_rd_reg <= seq_mem[rd_addr];
            fl_rd_reg  <= fl_mem[rd_addr];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_one_insert: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hits))
        else $error("more than one tail cell replaced in one cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LEN))
        else $error("stored word count exceeds capacity");

    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (!p1_valid_reg && !p2_valid_reg && !fl_wr_reg))
        else $error("result taken before backward pipeline drained");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.wavio_length != '0))
        else $error("wavio length below one");

endmodule

@@ sv/wlpl_cell.sv @@
// One tail cell of the patience-sorting row: holds one tail key and its valid bit.
// Depends on wlpl_pkg.
module wlpl_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  wlpl_pkg::cell_ctl_t ctl,
    input  wlpl_pkg::key_t     key,
    input  logic               prev_ge,
    output logic               ge,
    output logic               hit
);
    import wlpl_pkg::*;

    logic valid_reg;
    logic valid_next;
    logic hit_reg;
    logic hit_next;
    key_t tail_reg;
    logic first;

    // An empty cell counts as not less than any key, so the row stays monotone.
    assign ge    = !valid_reg || (tail_reg >= key);
    assign first = ge && !prev_ge;
    assign hit   = hit_reg;

    always_comb
    begin
        valid_next = valid_reg;
        hit_next   = 1'b0;
        if (ctl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.en && first)
        begin
            valid_next = 1'b1;
            hit_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctl.clr && ctl.en && first)
        begin
            tail_reg <= key;
        end
    end

endmodule

@@ sv/wlpl_chain.sv @@
// Row of MAX_LEN tail cells plus the encoder that turns the registered hit
// vector into the insert position. Depends on wlpl_pkg and wlpl_cell.
module wlpl_chain (
    input  logic                      clk,
    input  logic                      rst_n,
    input  wlpl_pkg::cell_ctl_t       ctl,
    input  wlpl_pkg::key_t            key,
    output logic [wlpl_pkg::IDX_W-1:0] pos,
    output logic [wlpl_pkg::MAX_LEN-1:0] hits
);
    import wlpl_pkg::*;

    logic [MAX_LEN-1:0] ge;

    for (genvar g = 0; g < MAX_LEN; g++)
    begin : g_cell
        logic prev;
        if (g == 0)
        begin : g_head
            assign prev = 1'b0;
        end
        else
        begin : g_body
            assign prev = ge[g-1];
        end
        wlpl_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .key     (key),
            .prev_ge (prev),
            .ge      (ge[g]),
            .hit     (hits[g])
        );
    end

    // At most one cell hits per cycle, so OR-ing the indices encodes it.
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < MAX_LEN; i++)
        begin
            if (hits[i])
            begin
                pos = pos | IDX_W'(i);
            end
        end
    end

endmodule

@@ dv/wavio_longest_peak_length_unit_checker.sv @@
// Checker for the wavio length unit: watches the item and result channels,
// predicts the result word of each sequence and compares it field by field.
// Depends on wlpl_pkg for the word types and MAX_LEN.
module wavio_longest_peak_length_unit_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_stall,
    input  wlpl_pkg::item_word_t   item,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  wlpl_pkg::result_word_t result,
    output int                     mismatches,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import wlpl_pkg::*;

    logic signed [31:0] elems [MAX_LEN];
    int unsigned        rise_len [MAX_LEN];
    logic signed [31:0] rise_tails [MAX_LEN];
    logic signed [31:0] fall_tails [MAX_LEN];
    int unsigned        rise_n;
    int unsigned        elem_n;
    bit                 truncated;
    result_word_t       awaited [$];
    result_word_t       want;
    int                 err_count;

    // Finds the first tail that is not less than v, overwrites it and returns its index.
    function automatic int unsigned place_tail(input bit falling, input logic signed [31:0] v,
                                               input int unsigned n);
        int unsigned pos;
        pos = 0;
        if (falling)
        begin
            while (pos < n && fall_tails[pos] < v)
                pos++;
            fall_tails[pos] = v;
        end
        else
        begin
            while (pos < n && rise_tails[pos] < v)
                pos++;
            rise_tails[pos] = v;
        end
        return pos;
    endfunction

    function automatic void absorb_word(input item_word_t w);
        int unsigned  pos;
        int unsigned  fall_n;
        int unsigned  m;
        int unsigned  best;
        int           i;
        result_word_t fresh;
        if (elem_n < MAX_LEN)
        begin
            pos = place_tail(1'b0, w.value, rise_n);
            if (pos == rise_n)
                rise_n++;
            elems[elem_n] = w.value;
            rise_len[elem_n] = pos + 1;
            elem_n++;
        end
        else
        begin
            truncated = 1'b1;
        end
        if (w.last)
        begin
            best = 1;
            fall_n = 0;
            // Walk the stored sequence from the right to get the falling side lengths.
            for (i = int'(elem_n) - 1; i >= 0; i--)
            begin
                pos = place_tail(1'b1, elems[i], fall_n);
                if (pos == fall_n)
                    fall_n++;
                m = (rise_len[i] < pos + 1) ? rise_len[i] : pos + 1;
                if (2 * m - 1 > best)
                    best = 2 * m - 1;
            end
            fresh.wavio_length = best[LEN_W-1:0];
            fresh.overflow = truncated;
            awaited.insert(awaited.size(), fresh);
            rise_n = 0;
            elem_n = 0;
            truncated = 1'b0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_n = 0;
            elem_n = 0;
            truncated = 1'b0;
            err_count = 0;
            awaited.delete();
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                absorb_word(item);
            if (result_valid && !result_stall)
            begin
                if (awaited.size() == 0)
                begin
                    $error("result word arrived with no prediction pending");
                    err_count++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (result.wavio_length !== want.wavio_length)
                    begin
                        $error("wavio_length: expected %0d, got %0d",
                               want.wavio_length, result.wavio_length);
                        err_count++;
                    end
                    if (result.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0d, got %0d",
                               want.overflow, result.overflow);
                        err_count++;
                    end
                end
            end
            mismatches <= err_count;
            outstanding <= awaited.size();
        end
    end

endmodule

@@ dv/wavio_longest_peak_length_unit_tb.sv @@
// Testbench top for the wavio length unit: clock, reset, sequence stimulus with
// random gaps and result stalls, and the final verdict.
// Depends on wlpl_pkg, the unit itself and wavio_longest_peak_length_unit_checker.
module wavio_longest_peak_length_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wlpl_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    typedef enum int {SHAPE_WILD, SHAPE_NARROW, SHAPE_FLAT, SHAPE_PEAK} shape_e;

    logic         clk;
    logic         rst_n;
    logic         item_valid;
    logic         item_stall;
    item_word_t   item;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_word_t result;

    int           mismatches;
    int           outstanding;
    int           stall_left = 0;
    int           hold;
    int unsigned  cycles = 0;
    int           words_sent = 0;
    bit           quiet = 1'b0;
    logic signed [31:0] seq_words [$];

    wavio_longest_peak_length_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    wavio_longest_peak_length_unit_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Each result word is held off by a randomly drawn stall, possibly none, once it shows up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (result_valid)
        begin
            if (!result_stall)
            begin
                hold = $urandom_range(0, 3);
                stall_left <= hold;
                result_stall <= (hold != 0);
            end
            else
            begin
                stall_left <= stall_left - 1;
                result_stall <= (stall_left > 1);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_word(input logic signed [31:0] v, input logic fin);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= item_word_t'{value: v, last: fin};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic play_sequence();
        foreach (seq_words[k])
            send_word(seq_words[k], k == seq_words.size() - 1);
    endtask

    task automatic build_random(input int len, input shape_e shape);
        logic signed [31:0] v;
        int peak;
        seq_words.delete();
        v = $urandom;
        peak = $urandom_range(0, len - 1);
        for (int k = 0; k < len; k++)
        begin
            unique case (shape)
                SHAPE_WILD:   v = $urandom;
                SHAPE_NARROW: v = $signed($urandom_range(0, 16)) - 8;
                SHAPE_FLAT:   ;
                default:
                begin
                    // Climb up to the peak, then descend; zero steps make equal neighbors.
                    if (k <= peak)
                        v = v + $urandom_range(0, 3);
                    else
                        v = v - $urandom_range(0, 3);
                    if ($urandom_range(0, 7) == 0)
                        v = v + $signed($urandom_range(0, 8)) - 4;
                end
            endcase
            if (shape != SHAPE_FLAT && $urandom_range(0, 15) == 0)
                v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
            seq_words.insert(seq_words.size(), v);
        end
    endtask

    initial
    begin
        int seq_count;
        int len;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        seq_words = '{VAL_MIN};
        play_sequence();
        seq_words = '{VAL_MAX};
        play_sequence();
        seq_words = '{VAL_MIN, -32'sd1, 32'sd0, VAL_MAX, 32'sd0, -32'sd1, VAL_MIN};
        play_sequence();
        seq_words = '{32'sd3, 32'sd3, 32'sd3};
        play_sequence();
        seq_words = '{32'sd1, 32'sd2, 32'sd3, 32'sd4};
        play_sequence();
        seq_words = '{32'sd9, 32'sd8, 32'sd7};
        play_sequence();
        seq_words = '{32'sd0, 32'sd5, 32'sd5, 32'sd0};
        play_sequence();

        seq_count = 0;
        while (words_sent < 1550 || seq_count < 24)
        begin
            if (seq_count == 12)
            begin
                // Two words past capacity, and the final one is among those dropped.
                build_random(MAX_LEN + 2, SHAPE_PEAK);
            end
            else
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80)
                                                  : $urandom_range(1, 24);
                build_random(len, shape_e'($urandom_range(0, 3)));
            end
            quiet = ($urandom_range(0, 3) == 0);
            play_sequence();
            seq_count++;
        end
        item_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
